// File: hw/rtl/ofb_pkg.sv
// ----------------------------------------------------------------------------
// ofb_pkg
// Shared constants of the orthonormal frame builder: status codes, field
// widths and the normalization target.
// ----------------------------------------------------------------------------
package ofb_pkg;

  localparam int unsigned OutW     = 16;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned ThrW     = 15;
  localparam logic [ThrW-1:0] ThrReset = 15'd1;

  // the largest shifted magnitude lives in [2^30, 2^31)
  localparam int unsigned MagW     = 32;
  localparam int unsigned NormTop  = 30;

  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StPrimZero = 2'd1;
  localparam logic [StatusW-1:0] StSecZero  = 2'd2;
  localparam logic [StatusW-1:0] StParallel = 2'd3;

endpackage

// File: hw/rtl/ofb_isqrt.sv
// ----------------------------------------------------------------------------
// ofb_isqrt
// Pipelined integer square root, one result bit per stage, with a sideband
// that travels alongside.
// ----------------------------------------------------------------------------
module ofb_isqrt import ofb_pkg::*; #(
  parameter int unsigned VW = 64,
  parameter int unsigned SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [VW-1:0]     rad_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output logic [VW/2-1:0]   root_o,
  output logic [SW-1:0]     side_o
);

  localparam int unsigned N = VW / 2;

  logic [VW-1:0] rem_q  [N];
  logic [VW-1:0] root_q [N];
  logic [SW-1:0] side_q [N];
  logic          vld_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int unsigned Sh = VW - 2 - 2 * k;
    localparam logic [VW:0] Bit = (VW+1)'(1) << Sh;

    logic [VW-1:0] rem_c, root_c, rem_d, root_d;
    logic [SW-1:0] side_c;
    logic          vld_c;
    logic [VW:0]   trial;

    if (k == 0) begin : g_first
      assign rem_c  = rad_i;
      assign root_c = '0;
      assign side_c = side_i;
      assign vld_c  = valid_i;
    end else begin : g_next
      assign rem_c  = rem_q[k-1];
      assign root_c = root_q[k-1];
      assign side_c = side_q[k-1];
      assign vld_c  = vld_q[k-1];
    end

    always_comb begin
      trial = {1'b0, root_c} + Bit;
      if ({1'b0, rem_c} >= trial) begin
        rem_d  = rem_c - trial[VW-1:0];
        root_d = (root_c >> 1) + Bit[VW-1:0];
      end else begin
        rem_d  = rem_c;
        root_d = root_c >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
      side_q[k] <= side_c;
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1][N-1:0];
  assign side_o  = side_q[N-1];

endmodule

// File: hw/rtl/ofb_norm.sv
// ----------------------------------------------------------------------------
// ofb_norm
// Pipelined 3D vector normalizer: magnitude, leading-one shift, sum of
// squares, square root and a restoring divider per component.
// ----------------------------------------------------------------------------
module ofb_norm import ofb_pkg::*; #(
  parameter int unsigned IW = 16,
  parameter int unsigned F  = 14,
  parameter int unsigned SW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [IW-1:0] vec_i [3],
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic                nz_o,
  output logic signed [F+1:0] vec_o [3],
  output logic [SW-1:0]       side_o
);

  localparam int unsigned SqW = 2 * MagW;
  localparam int unsigned ShW = $clog2(MagW);
  localparam int unsigned QW  = F + 1;
  localparam int unsigned DW  = MagW + F + 1;
  localparam int unsigned OW  = F + 2;
  localparam int unsigned NSW = SW + 1 + 3 + 3 * MagW;
  localparam logic [QW-1:0] OneQ = QW'(1) << F;

  // stage 1: magnitudes
  logic [IW-1:0] mag1_q [3];
  logic [2:0]    sgn1_q;
  logic [SW-1:0] side1_q;
  logic          v1_q;

  // stage 2: largest magnitude
  logic [IW-1:0] mag2_q [3];
  logic [IW-1:0] mx2_q;
  logic [2:0]    sgn2_q;
  logic [SW-1:0] side2_q;
  logic          v2_q;

  // stage 3: shifted magnitudes
  logic [MagW-1:0] m3_q [3];
  logic            nz3_q;
  logic [2:0]      sgn3_q;
  logic [SW-1:0]   side3_q;
  logic            v3_q;

  // stage 4: squares
  logic [SqW-1:0]  sq4_q [3];
  logic [MagW-1:0] m4_q [3];
  logic            nz4_q;
  logic [2:0]      sgn4_q;
  logic [SW-1:0]   side4_q;
  logic            v4_q;

  // stage 5: sum of squares
  logic [SqW-1:0]  n2_q;
  logic [MagW-1:0] m5_q [3];
  logic            nz5_q;
  logic [2:0]      sgn5_q;
  logic [SW-1:0]   side5_q;
  logic            v5_q;

  logic [IW-1:0]   mag_c [3];
  logic [IW-1:0]   mx_c;
  logic [MagW-1:0] mx32;
  logic [ShW-1:0]  pos_c, sh_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec_i[i][IW-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
    end
  end

  always_comb begin
    mx_c = mag1_q[0];
    if (mag1_q[1] > mx_c) mx_c = mag1_q[1];
    if (mag1_q[2] > mx_c) mx_c = mag1_q[2];
  end

  always_comb begin
    mx32  = MagW'(mx2_q);
    pos_c = '0;
    for (int b = 0; b < MagW; b++) begin
      if (mx32[b]) pos_c = ShW'(b);
    end
    sh_c = (pos_c >= ShW'(NormTop)) ? '0 : ShW'(NormTop) - pos_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      mag1_q[i] <= mag_c[i];
      sgn1_q[i] <= vec_i[i][IW-1];
      mag2_q[i] <= mag1_q[i];
      m3_q[i]   <= MagW'(mag2_q[i]) << sh_c;
      sq4_q[i]  <= SqW'(m3_q[i]) * SqW'(m3_q[i]);
      m4_q[i]   <= m3_q[i];
      m5_q[i]   <= m4_q[i];
    end
    side1_q <= side_i;
    mx2_q   <= mx_c;
    sgn2_q  <= sgn1_q;
    side2_q <= side1_q;
    nz3_q   <= (mx2_q != '0);
    sgn3_q  <= sgn2_q;
    side3_q <= side2_q;
    nz4_q   <= nz3_q;
    sgn4_q  <= sgn3_q;
    side4_q <= side3_q;
    n2_q    <= sq4_q[0] + sq4_q[1] + sq4_q[2];
    nz5_q   <= nz4_q;
    sgn5_q  <= sgn4_q;
    side5_q <= side4_q;
  end

  // square root
  logic [NSW-1:0]  rt_side_i, rt_side_o;
  logic [MagW-1:0] len_c;
  logic            rt_valid;
  logic [MagW-1:0] mr_c [3];
  logic            nzr_c;
  logic [2:0]      sgnr_c;
  logic [SW-1:0]   sider_c;

  assign rt_side_i = {side5_q, nz5_q, sgn5_q, m5_q[2], m5_q[1], m5_q[0]};

  ofb_isqrt #(
    .VW (SqW),
    .SW (NSW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .rad_i   (n2_q),
    .side_i  (rt_side_i),
    .valid_o (rt_valid),
    .root_o  (len_c),
    .side_o  (rt_side_o)
  );

  assign {sider_c, nzr_c, sgnr_c, mr_c[2], mr_c[1], mr_c[0]} = rt_side_o;

  // dividend setup, rounding folded in
  logic [DW-1:0]   num0_q [3];
  logic [MagW-1:0] len0_q;
  logic            nz0_q;
  logic [2:0]      sgn0_q;
  logic [SW-1:0]   side0_q;
  logic            v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= rt_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      num0_q[i] <= (DW'(mr_c[i]) << F) + DW'(len_c >> 1);
    end
    len0_q  <= len_c;
    nz0_q   <= nzr_c;
    sgn0_q  <= sgnr_c;
    side0_q <= sider_c;
  end

  // restoring division, one quotient bit per stage
  logic [DW-1:0]   rem_q  [QW][3];
  logic [QW-1:0]   quo_q  [QW][3];
  logic [MagW-1:0] dlen_q [QW];
  logic            dnz_q  [QW];
  logic [2:0]      dsgn_q [QW];
  logic [SW-1:0]   dside_q[QW];
  logic            dv_q   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int unsigned K = QW - 1 - j;

    logic [DW-1:0]   rem_c [3];
    logic [QW-1:0]   quo_c [3];
    logic [DW-1:0]   rem_d [3];
    logic [QW-1:0]   quo_d [3];
    logic [MagW-1:0] len_s;
    logic            nz_s;
    logic [2:0]      sgn_s;
    logic [SW-1:0]   side_s;
    logic            v_s;
    logic [DW-1:0]   cmp;

    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_c[i] = num0_q[i];
          quo_c[i] = '0;
        end
      end
      assign len_s  = len0_q;
      assign nz_s   = nz0_q;
      assign sgn_s  = sgn0_q;
      assign side_s = side0_q;
      assign v_s    = v0_q;
    end else begin : g_next
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_c[i] = rem_q[j-1][i];
          quo_c[i] = quo_q[j-1][i];
        end
      end
      assign len_s  = dlen_q[j-1];
      assign nz_s   = dnz_q[j-1];
      assign sgn_s  = dsgn_q[j-1];
      assign side_s = dside_q[j-1];
      assign v_s    = dv_q[j-1];
    end

    always_comb begin
      cmp = DW'(len_s) << K;
      for (int i = 0; i < 3; i++) begin
        if (rem_c[i] >= cmp) begin
          rem_d[i] = rem_c[i] - cmp;
          quo_d[i] = quo_c[i] | (QW'(1) << K);
        end else begin
          rem_d[i] = rem_c[i];
          quo_d[i] = quo_c[i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else begin
        dv_q[j] <= v_s;
      end
    end

    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[j][i] <= rem_d[i];
        quo_q[j][i] <= quo_d[i];
      end
      dlen_q[j]  <= len_s;
      dnz_q[j]   <= nz_s;
      dsgn_q[j]  <= sgn_s;
      dside_q[j] <= side_s;
    end
  end

  // sign and clamp
  logic [QW-1:0]        qs_c [3];
  logic signed [OW-1:0] out_c [3];
  logic signed [OW-1:0] out_q [3];
  logic                 nzo_q;
  logic [SW-1:0]        sideo_q;
  logic                 vo_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs_c[i]  = (quo_q[QW-1][i] > OneQ) ? OneQ : quo_q[QW-1][i];
      out_c[i] = dsgn_q[QW-1][i] ? -$signed(OW'(qs_c[i])) : $signed(OW'(qs_c[i]));
      if (!dnz_q[QW-1]) out_c[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= dv_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      out_q[i] <= out_c[i];
    end
    nzo_q   <= dnz_q[QW-1];
    sideo_q <= dside_q[QW-1];
  end

  assign valid_o = vo_q;
  assign nz_o    = nzo_q;
  assign vec_o   = out_q;
  assign side_o  = sideo_q;

endmodule

// File: hw/rtl/orthonormal_frame_builder.sv
// ----------------------------------------------------------------------------
// orthonormal_frame_builder
// Gram-Schmidt frame from a primary and a secondary 3D direction, Q1.14 out.
//
//  channel   | signals                                  | transfer when
//  ----------+------------------------------------------+----------------------
//  command   | start, busy, primary_*_i, secondary_*_i  | start && !busy
//  result    | done_o, axis_*_o, status_o               | done_o (one cycle)
//  config    | cfg_valid_i, cfg_ready_o, cfg_data_i     | cfg_valid_i && cfg_ready_o
//
// One item per cycle; busy is never raised. The pipeline passes through two
// normalizers (each holding a 32-stage square root and a FRAC_BITS+1 stage
// divider) and the projected-length root (FRAC_BITS+4 stages). Reset clears
// all valid bits and loads the threshold.
// Results cannot be held off; nothing in the pipeline stalls.
// ----------------------------------------------------------------------------
module orthonormal_frame_builder import ofb_pkg::*; #(
  parameter int unsigned IN_WIDTH  = 16,
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [IN_WIDTH-1:0] primary_x_i,
  input  logic signed [IN_WIDTH-1:0] primary_y_i,
  input  logic signed [IN_WIDTH-1:0] primary_z_i,
  input  logic signed [IN_WIDTH-1:0] secondary_x_i,
  input  logic signed [IN_WIDTH-1:0] secondary_y_i,
  input  logic signed [IN_WIDTH-1:0] secondary_z_i,
  output logic                       done_o,
  output logic signed [OutW-1:0]     axis_x_0_o,
  output logic signed [OutW-1:0]     axis_x_1_o,
  output logic signed [OutW-1:0]     axis_x_2_o,
  output logic signed [OutW-1:0]     axis_y_0_o,
  output logic signed [OutW-1:0]     axis_y_1_o,
  output logic signed [OutW-1:0]     axis_y_2_o,
  output logic signed [OutW-1:0]     axis_z_0_o,
  output logic signed [OutW-1:0]     axis_z_1_o,
  output logic signed [OutW-1:0]     axis_z_2_o,
  output logic [StatusW-1:0]         status_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ThrW-1:0]            cfg_data_i
);

  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned XW  = F + 2;
  localparam int unsigned YW  = F + 3;
  localparam int unsigned RW  = 2 * F + 6;
  localparam int unsigned LW  = 2 * YW + 2;
  localparam int unsigned LRW = LW / 2;
  localparam int unsigned CmpW = (LRW > ThrW) ? LRW : ThrW;
  localparam int unsigned LSW = ThrW + 2 + 3 * XW + 3 * YW;
  localparam int unsigned YSW = StatusW + 3 * XW;
  localparam logic [RW-1:0] Half = RW'(1) << (F - 1);
  localparam logic signed [RW-1:0] Lim1 = RW'(1) << F;
  localparam logic signed [RW-1:0] Lim2 = RW'(1) << (F + 1);

  function automatic logic signed [RW-1:0] rnd_frac(input logic signed [RW-1:0] v);
    logic [RW-1:0] mag, q;
    mag = v[RW-1] ? RW'(-v) : RW'(v);
    q   = (mag + Half) >> F;
    return v[RW-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [RW-1:0] sat_lim(input logic signed [RW-1:0] v,
                                                   input logic signed [RW-1:0] lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // configuration
  logic [ThrW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  logic in_xfer;
  assign in_xfer = start && !busy;

  // primary and secondary normalization
  logic signed [IN_WIDTH-1:0] pvec [3];
  logic signed [IN_WIDTH-1:0] svec [3];
  logic signed [XW-1:0]       xn [3];
  logic signed [XW-1:0]       sn [3];
  logic                       nzp, nzs, vn;
  logic [ThrW-1:0]            thr_n;

  assign pvec[0] = primary_x_i;
  assign pvec[1] = primary_y_i;
  assign pvec[2] = primary_z_i;
  assign svec[0] = secondary_x_i;
  assign svec[1] = secondary_y_i;
  assign svec[2] = secondary_z_i;

  ofb_norm #(
    .IW (IN_WIDTH),
    .F  (F),
    .SW (ThrW)
  ) u_norm_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_xfer),
    .vec_i   (pvec),
    .side_i  (thr_q),
    .valid_o (vn),
    .nz_o    (nzp),
    .vec_o   (xn),
    .side_o  (thr_n)
  );

  ofb_norm #(
    .IW (IN_WIDTH),
    .F  (F),
    .SW (1)
  ) u_norm_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_xfer),
    .vec_i   (svec),
    .side_i  (1'b0),
    .valid_o (),
    .nz_o    (nzs),
    .vec_o   (sn),
    .side_o  ()
  );

  // projection and remainder
  logic signed [RW-1:0] pr1_q [3];
  logic signed [XW-1:0] x1_q [3], s1_q [3];
  logic                 nzp1_q, nzs1_q, v1_q;
  logic [ThrW-1:0]      thr1_q;

  logic signed [RW-1:0] dot2_q;
  logic signed [XW-1:0] x2_q [3], s2_q [3];
  logic                 nzp2_q, nzs2_q, v2_q;
  logic [ThrW-1:0]      thr2_q;

  logic signed [YW-1:0] d3_q;
  logic signed [XW-1:0] x3_q [3], s3_q [3];
  logic                 nzp3_q, nzs3_q, v3_q;
  logic [ThrW-1:0]      thr3_q;

  logic signed [RW-1:0] dx4_q [3];
  logic signed [XW-1:0] x4_q [3], s4_q [3];
  logic                 nzp4_q, nzs4_q, v4_q;
  logic [ThrW-1:0]      thr4_q;

  logic signed [YW-1:0] yr5_q [3];
  logic signed [XW-1:0] x5_q [3];
  logic                 nzp5_q, nzs5_q, v5_q;
  logic [ThrW-1:0]      thr5_q;

  logic [LW-1:0]        sq6_q [3];
  logic signed [YW-1:0] yr6_q [3];
  logic signed [XW-1:0] x6_q [3];
  logic                 nzp6_q, nzs6_q, v6_q;
  logic [ThrW-1:0]      thr6_q;

  logic [LW-1:0]        ly7_q;
  logic signed [YW-1:0] yr7_q [3];
  logic signed [XW-1:0] x7_q [3];
  logic                 nzp7_q, nzs7_q, v7_q;
  logic [ThrW-1:0]      thr7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v1_q <= vn;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pr1_q[i] <= RW'(xn[i]) * RW'(sn[i]);
      x1_q[i]  <= xn[i];
      s1_q[i]  <= sn[i];
      x2_q[i]  <= x1_q[i];
      s2_q[i]  <= s1_q[i];
      x3_q[i]  <= x2_q[i];
      s3_q[i]  <= s2_q[i];
      dx4_q[i] <= RW'(d3_q) * RW'(x3_q[i]);
      x4_q[i]  <= x3_q[i];
      s4_q[i]  <= s3_q[i];
      yr5_q[i] <= YW'(sat_lim(RW'(s4_q[i]) - rnd_frac(dx4_q[i]), Lim2));
      x5_q[i]  <= x4_q[i];
      sq6_q[i] <= LW'($unsigned(RW'(yr5_q[i]) * RW'(yr5_q[i])));
      yr6_q[i] <= yr5_q[i];
      x6_q[i]  <= x5_q[i];
      yr7_q[i] <= yr6_q[i];
      x7_q[i]  <= x6_q[i];
    end
    dot2_q <= pr1_q[0] + pr1_q[1] + pr1_q[2];
    d3_q   <= YW'(sat_lim(rnd_frac(dot2_q), Lim2));
    ly7_q  <= sq6_q[0] + sq6_q[1] + sq6_q[2];
    nzp1_q <= nzp;
    nzs1_q <= nzs;
    thr1_q <= thr_n;
    nzp2_q <= nzp1_q;
    nzs2_q <= nzs1_q;
    thr2_q <= thr1_q;
    nzp3_q <= nzp2_q;
    nzs3_q <= nzs2_q;
    thr3_q <= thr2_q;
    nzp4_q <= nzp3_q;
    nzs4_q <= nzs3_q;
    thr4_q <= thr3_q;
    nzp5_q <= nzp4_q;
    nzs5_q <= nzs4_q;
    thr5_q <= thr4_q;
    nzp6_q <= nzp5_q;
    nzs6_q <= nzs5_q;
    thr6_q <= thr5_q;
    nzp7_q <= nzp6_q;
    nzs7_q <= nzs6_q;
    thr7_q <= thr6_q;
  end

  // remainder length
  logic [LSW-1:0]       ls_side_i, ls_side_o;
  logic [LRW-1:0]       ly_root;
  logic                 ls_valid;
  logic [ThrW-1:0]      thr_l;
  logic                 nzp_l, nzs_l;
  logic signed [XW-1:0] x_l [3];
  logic signed [YW-1:0] yr_l [3];

  assign ls_side_i = {thr7_q, nzp7_q, nzs7_q, x7_q[2], x7_q[1], x7_q[0],
                      yr7_q[2], yr7_q[1], yr7_q[0]};

  ofb_isqrt #(
    .VW (LW),
    .SW (LSW)
  ) u_isqrt_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v7_q),
    .rad_i   (ly7_q),
    .side_i  (ls_side_i),
    .valid_o (ls_valid),
    .root_o  (ly_root),
    .side_o  (ls_side_o)
  );

  assign {thr_l, nzp_l, nzs_l, x_l[2], x_l[1], x_l[0], yr_l[2], yr_l[1], yr_l[0]} = ls_side_o;

  // status decision
  logic [StatusW-1:0]   st_c;
  logic [StatusW-1:0]   st8_q;
  logic signed [XW-1:0] x8_q [3];
  logic signed [YW-1:0] yr8_q [3];
  logic                 v8_q;

  always_comb begin
    if (!nzp_l) begin
      st_c = StPrimZero;
    end else if (!nzs_l) begin
      st_c = StSecZero;
    end else if (CmpW'(ly_root) <= CmpW'(thr_l)) begin
      st_c = StParallel;
    end else begin
      st_c = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else begin
      v8_q <= ls_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      x8_q[i]  <= x_l[i];
      yr8_q[i] <= yr_l[i];
    end
    st8_q <= st_c;
  end

  // remainder normalization
  logic [YSW-1:0]       ys_side_i, ys_side_o;
  logic signed [XW-1:0] yn [3];
  logic signed [XW-1:0] x_y [3];
  logic [StatusW-1:0]   st_y;
  logic                 vy;

  assign ys_side_i = {st8_q, x8_q[2], x8_q[1], x8_q[0]};

  ofb_norm #(
    .IW (YW),
    .F  (F),
    .SW (YSW)
  ) u_norm_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v8_q),
    .vec_i   (yr8_q),
    .side_i  (ys_side_i),
    .valid_o (vy),
    .nz_o    (),
    .vec_o   (yn),
    .side_o  (ys_side_o)
  );

  assign {st_y, x_y[2], x_y[1], x_y[0]} = ys_side_o;

  // cross product
  logic signed [RW-1:0] cp_q [6];
  logic signed [XW-1:0] xc1_q [3], yc1_q [3];
  logic [StatusW-1:0]   stc1_q;
  logic                 vc1_q;

  logic signed [XW-1:0] z2_q [3];
  logic signed [XW-1:0] xc2_q [3], yc2_q [3];
  logic [StatusW-1:0]   stc2_q;
  logic                 vc2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc1_q  <= 1'b0;
      vc2_q  <= 1'b0;
      done_o <= 1'b0;
    end else begin
      vc1_q  <= vy;
      vc2_q  <= vc1_q;
      done_o <= vc2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q[0] <= RW'(x_y[1]) * RW'(yn[2]);
    cp_q[1] <= RW'(x_y[2]) * RW'(yn[1]);
    cp_q[2] <= RW'(x_y[2]) * RW'(yn[0]);
    cp_q[3] <= RW'(x_y[0]) * RW'(yn[2]);
    cp_q[4] <= RW'(x_y[0]) * RW'(yn[1]);
    cp_q[5] <= RW'(x_y[1]) * RW'(yn[0]);
    for (int i = 0; i < 3; i++) begin
      xc1_q[i] <= x_y[i];
      yc1_q[i] <= yn[i];
      z2_q[i]  <= XW'(sat_lim(rnd_frac(cp_q[2*i] - cp_q[2*i+1]), Lim1));
      xc2_q[i] <= xc1_q[i];
      yc2_q[i] <= yc1_q[i];
    end
    stc1_q <= st_y;
    stc2_q <= stc1_q;
  end

  // result register
  logic ok_c;
  assign ok_c = (stc2_q == StOk);

  always_ff @(posedge clk_i) begin
    axis_x_0_o <= ok_c ? OutW'(xc2_q[0]) : '0;
    axis_x_1_o <= ok_c ? OutW'(xc2_q[1]) : '0;
    axis_x_2_o <= ok_c ? OutW'(xc2_q[2]) : '0;
    axis_y_0_o <= ok_c ? OutW'(yc2_q[0]) : '0;
    axis_y_1_o <= ok_c ? OutW'(yc2_q[1]) : '0;
    axis_y_2_o <= ok_c ? OutW'(yc2_q[2]) : '0;
    axis_z_0_o <= ok_c ? OutW'(z2_q[0]) : '0;
    axis_z_1_o <= ok_c ? OutW'(z2_q[1]) : '0;
    axis_z_2_o <= ok_c ? OutW'(z2_q[2]) : '0;
    status_o   <= stc2_q;
  end

`ifndef SYNTHESIS
  a_err_zero_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != StOk |->
      axis_x_0_o == '0 && axis_x_1_o == '0 && axis_x_2_o == '0 &&
      axis_y_0_o == '0 && axis_y_1_o == '0 && axis_y_2_o == '0 &&
      axis_z_0_o == '0 && axis_z_1_o == '0 && axis_z_2_o == '0)
    else $error("error result carries a nonzero frame");

  a_ok_axis_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == StOk |->
      (axis_x_0_o != '0 || axis_x_1_o != '0 || axis_x_2_o != '0) &&
      (axis_y_0_o != '0 || axis_y_1_o != '0 || axis_y_2_o != '0))
    else $error("ok result with a zero axis");

  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> thr_q == $past(cfg_data_i))
    else $error("threshold write lost");
`endif

endmodule

// File: tb/orthonormal_frame_builder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orthonormal_frame_builder_tb
// Drives direction pairs through the frame builder and checks every frame
// and status code against a behavioral Gram-Schmidt predictor, across
// several parallel-threshold settings, with random gaps between commands except in the final run.
// ----------------------------------------------------------------------------
module orthonormal_frame_builder_tb import ofb_pkg::*;;

  localparam int Latency = 3 * 14 + 95;
  localparam int CycleLimit = 400000;
  localparam longint One = 64'd1 << 14;

  typedef longint vec3_t [3];
  typedef struct {
    logic [OutW-1:0]    axis [9];
    logic [StatusW-1:0] status;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] primary_x_i = '0, primary_y_i = '0, primary_z_i = '0;
  logic signed [15:0] secondary_x_i = '0, secondary_y_i = '0, secondary_z_i = '0;
  logic done_o;
  logic signed [OutW-1:0] axis_x_0_o, axis_x_1_o, axis_x_2_o;
  logic signed [OutW-1:0] axis_y_0_o, axis_y_1_o, axis_y_2_o;
  logic signed [OutW-1:0] axis_z_0_o, axis_z_1_o, axis_z_2_o;
  logic [StatusW-1:0] status_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [ThrW-1:0] cfg_data_i = '0;

  frame_t frames_due [$];
  logic [ThrW-1:0] threshold_model;
  int errors = 0;
  int cycles = 0;
  bit gaps_on = 1'b1;

  orthonormal_frame_builder uut (
    .clk_i, .rst_ni, .start, .busy,
    .primary_x_i, .primary_y_i, .primary_z_i,
    .secondary_x_i, .secondary_y_i, .secondary_z_i,
    .done_o,
    .axis_x_0_o, .axis_x_1_o, .axis_x_2_o,
    .axis_y_0_o, .axis_y_1_o, .axis_y_2_o,
    .axis_z_0_o, .axis_z_1_o, .axis_z_2_o,
    .status_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint div_round(longint num, longint unsigned den);
    longint unsigned m, q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic bit unit_vec(input vec3_t v, output vec3_t o);
    longint unsigned m [3];
    longint unsigned mx, n2, len, q;
    int sh;
    mx = 0;
    n2 = 0;
    sh = 0;
    o = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 1'b0;
    while ((mx << sh) < (64'd1 << 30)) sh++;
    for (int i = 0; i < 3; i++) begin
      m[i] <<= sh;
      n2 += m[i] * m[i];
    end
    len = isqrt(n2);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 14) + len / 2) / len;
      if (q > One) q = One;
      o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic frame_t build_frame(vec3_t p, vec3_t s0, logic [ThrW-1:0] thr);
    frame_t f;
    vec3_t x, s, y, yr, z;
    longint dot, d;
    longint unsigned ly2;
    logic [StatusW-1:0] st;
    dot = 0;
    ly2 = 0;
    st = StOk;
    z = '{0, 0, 0};
    y = '{0, 0, 0};
    if (!unit_vec(p, x)) begin
      st = StPrimZero;
    end else if (!unit_vec(s0, s)) begin
      st = StSecZero;
    end else begin
      for (int i = 0; i < 3; i++) dot += x[i] * s[i];
      d = clamp(div_round(dot, One), 2 * One);
      for (int i = 0; i < 3; i++) begin
        yr[i] = clamp(s[i] - div_round(d * x[i], One), 2 * One);
        ly2 += longint'(yr[i] * yr[i]);
      end
      if (isqrt(ly2) <= thr || !unit_vec(yr, y)) begin
        st = StParallel;
      end else begin
        z[0] = clamp(div_round(x[1] * y[2] - x[2] * y[1], One), One);
        z[1] = clamp(div_round(x[2] * y[0] - x[0] * y[2], One), One);
        z[2] = clamp(div_round(x[0] * y[1] - x[1] * y[0], One), One);
      end
    end
    for (int i = 0; i < 3; i++) begin
      f.axis[i]     = (st == StOk) ? x[i][15:0] : '0;
      f.axis[3 + i] = (st == StOk) ? y[i][15:0] : '0;
      f.axis[6 + i] = (st == StOk) ? z[i][15:0] : '0;
    end
    f.status = st;
    return f;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    logic [OutW-1:0] got [9];
    frame_t want;
    if (done_o) begin
      got = '{axis_x_0_o, axis_x_1_o, axis_x_2_o, axis_y_0_o, axis_y_1_o,
              axis_y_2_o, axis_z_0_o, axis_z_1_o, axis_z_2_o};
      if (frames_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, status %0d", $time, status_o);
      end else begin
        want = frames_due.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== want.axis[i]) begin
            errors++;
            $display("%0t: axis entry %0d expected %0d actual %0d", $time, i,
                     $signed(want.axis[i]), $signed(got[i]));
          end
        end
        if (status_o !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_pair(input logic signed [15:0] px, py, pz, sx, sy, sz);
    bit ok;
    vec3_t p, s;
    start <= 1'b1;
    primary_x_i <= px;
    primary_y_i <= py;
    primary_z_i <= pz;
    secondary_x_i <= sx;
    secondary_y_i <= sy;
    secondary_z_i <= sz;
    do begin
      @(negedge clk_i);
      ok = !busy;
      @(posedge clk_i);
    end while (!ok);
    p = '{px, py, pz};
    s = '{sx, sy, sz};
    frames_due.insert(frames_due.size(), build_frame(p, s, threshold_model));
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [ThrW-1:0] thr);
    bit ok;
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= thr;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
    threshold_model = thr;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($signed($urandom_range(0, 16)) - 8);
      default: return 16'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic logic signed [15:0] near_comp(logic signed [15:0] v, int k,
                                                   int noise);
    longint t;
    t = (longint'(v) * k) / 4 + $signed($urandom_range(0, 2 * noise)) - noise;
    return 16'(clamp(t, 32767));
  endfunction

  task automatic random_pair(int nearness);
    logic signed [15:0] p [3], s [3];
    int mode, k;
    mode = $urandom_range(0, 3);
    k = $signed($urandom_range(0, 8)) - 4;
    for (int i = 0; i < 3; i++) p[i] = rand_comp(mode % 3);
    for (int i = 0; i < 3; i++) begin
      s[i] = (nearness > 0 && $urandom_range(0, 2) != 0) ?
             near_comp(p[i], (k == 0) ? 3 : k, nearness) : rand_comp(mode % 3);
    end
    if ($urandom_range(0, 40) == 0) p = '{0, 0, 0};
    if ($urandom_range(0, 40) == 0) s = '{0, 0, 0};
    send_pair(p[0], p[1], p[2], s[0], s[1], s[2]);
  endtask

  task automatic test_directed;
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(0, 0, 0, 1, 2, 3);
    send_pair(1, 0, 0, 0, 0, 0);
    send_pair(1, 0, 0, 0, 1, 0);
    send_pair(0, 1, 0, 0, 0, 1);
    send_pair(0, 0, -1, 1, 0, 0);
    send_pair(-32768, -32768, -32768, 32767, 32767, 32767);
    send_pair(32767, 32767, 32767, 32767, 32767, 32767);
    send_pair(-32768, 0, 0, 32767, -32768, 0);
    send_pair(32767, -32768, 32767, -32768, 32767, -32768);
    send_pair(5, 5, 5, -10, -10, -10);
    send_pair(1000, 1, 0, 1000, 0, 0);
    send_pair(1000, 20, 0, 1000, 0, 0);
    send_pair(-1, -1, -1, 1, -1, 1);
    send_pair(32767, 1, 1, 1, 32767, 1);
    send_pair(-21846, 21845, -1, 0, -32768, 32767);
  endtask

  task automatic test_threshold_extremes;
    logic [ThrW-1:0] levels [4] = '{15'd0, 15'd16384, 15'd32767, 15'd1};
    foreach (levels[j]) begin
      write_threshold(levels[j]);
      send_pair(1000, 20, 0, 1000, 0, 0);
      send_pair(1, 0, 0, 0, 1, 0);
      send_pair(3, -7, 2, -5, 1, 9);
      repeat (30) random_pair(20);
    end
  endtask

  task automatic test_random(int items, logic [ThrW-1:0] thr);
    write_threshold(thr);
    for (int i = 0; i < items; i++) random_pair(($urandom_range(0, 1) == 0) ? 0 :
                                                $urandom_range(1, 60));
  endtask

  initial begin
    threshold_model = ThrReset;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_threshold_extremes();
    test_random(300, 15'd1);
    test_random(250, 15'd200);
    test_random(250, 15'd4000);
    test_random(150, 15'($urandom_range(0, 32767)));
    gaps_on = 1'b0;
    test_random(200, 15'd40);
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
